// ----- hw/rtl/llbr_pkg.sv -----
// llbr_pkg: shared types and constants for the line-locked byte ring.
// Operation, status and control-state codes, plus the result record.
// No dependencies.
package llbr_pkg;

    localparam int DATA_W  = 8;
    localparam int FIELD_W = 16;
    localparam int COUNT_W = 17;

    localparam logic [DATA_W-1:0] NEWLINE = 8'h0A;

    typedef enum logic [1:0] {
        OP_WRITE,
        OP_READ,
        OP_ERASE,
        OP_FLUSH
    } op_t;

    typedef enum logic [1:0] {
        ST_OK,
        ST_EMPTY,
        ST_FULL,
        ST_UNSUPPORTED
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_ERASE,
        S_RESP
    } state_t;

    typedef struct packed {
        logic [DATA_W-1:0]  data_out;
        status_t            status;
        logic               line_ready;
        logic [COUNT_W-1:0] held_count;
    } result_t;

endpackage

// ----- hw/rtl/line_locked_byte_ring_unit.sv -----
// line_locked_byte_ring_unit: top level of the line-locked byte ring.
// Depends on llbr_pkg, llbr_ctrl and (through it) llbr_ram.
//
//   channel   handshake              payload
//   --------  ---------------------  --------------------------------------------------
//   in        in_valid / in_ready    op, data_in, last_of_call, use_start,
//                                    start_index, erase_offset
//   out       out_valid / out_ready  data_out, status, line_ready, held_count
//   cfg       cfg_wr_en              cfg_wr_data (wrap_mode_enabled)
//
// Write, read, flush, an erase with offset 1 and every refused or failed
// transaction pass through the execute state, which runs the transaction
// against the byte store, and the response state, which hands the result to
// the output register while the next transaction is accepted. A successful
// erase with offset k of 2 or more runs the erase walker between the two, moving
// one byte per cycle through the single read and single write port of the store.
// Reset is asynchronous, active low; the store itself is not cleared and no
// clearing pass runs. The output register takes a result while the next
// transaction is accepted; a stall on out_ready holds the sequencer in its
// response state until the register frees.
module line_locked_byte_ring_unit
    import llbr_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [DATA_W-1:0]  data_in,
    input  logic               last_of_call,
    input  logic               use_start,
    input  logic [FIELD_W-1:0] start_index,
    input  logic [FIELD_W-1:0] erase_offset,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [DATA_W-1:0]  data_out,
    output logic [1:0]         status,
    output logic               line_ready,
    output logic [COUNT_W-1:0] held_count
);

    logic    res_valid;
    logic    res_ready;
    result_t res;

    logic    out_valid_reg, out_valid_next;
    result_t out_res_reg;

    llbr_ctrl #(
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .data_in      (data_in),
        .last_of_call (last_of_call),
        .use_start    (use_start),
        .start_index  (start_index),
        .erase_offset (erase_offset),
        .res_valid    (res_valid),
        .res_ready    (res_ready),
        .res          (res)
    );

    // The output register frees when empty or when its transaction leaves.
    assign res_ready = !out_valid_reg || out_ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (res_ready)
        begin
            out_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    // Load a new result only on handoff; otherwise hold.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            out_res_reg <= res;
        end
    end

    assign out_valid  = out_valid_reg;
    assign data_out   = out_res_reg.data_out;
    assign status     = out_res_reg.status;
    assign line_ready = out_res_reg.line_ready;
    assign held_count = out_res_reg.held_count;

endmodule

// ----- hw/rtl/llbr_ram.sv -----
// llbr_ram: generic simple dual-port RAM, one write and one registered read port.
// No dependencies; contents are undefined until written.
module llbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 65536
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- hw/rtl/llbr_ctrl.sv -----
// llbr_ctrl: operation sequencer, ring pointers, line lock and erase walker.
// Depends on llbr_pkg and llbr_ram (the byte store).
module llbr_ctrl
    import llbr_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic               cfg_wr_data,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         op,
    input  logic [DATA_W-1:0]  data_in,
    input  logic               last_of_call,
    input  logic               use_start,
    input  logic [FIELD_W-1:0] start_index,
    input  logic [FIELD_W-1:0] erase_offset,
    output logic               res_valid,
    input  logic               res_ready,
    output result_t            res
);

    localparam int POS_W = INDEX_BITS + 1;
    localparam int DEPTH = 1 << INDEX_BITS;
    localparam logic [POS_W-1:0] STORE_SIZE = POS_W'(DEPTH);
    localparam logic [POS_W-1:0] ONE = POS_W'(1);

    state_t state_reg, state_next;

    logic [POS_W-1:0] rp_reg, rp_next;
    logic [POS_W-1:0] wp_reg, wp_next;
    logic [POS_W-1:0] lock_reg, lock_next;
    logic             open_reg, open_next;
    logic             cut_reg, cut_next;
    logic             wrap_reg;
    status_t          status_reg, status_next;
    logic             data_sel_reg, data_sel_next;

    // latched transaction
    op_t                   op_reg;
    logic [DATA_W-1:0]     data_reg;
    logic                  last_reg;
    logic                  use_start_reg;
    logic [INDEX_BITS-1:0] start_reg;
    logic [FIELD_W-1:0]    offset_reg;

    // erase walker
    logic [INDEX_BITS-1:0] src_reg, src_next;
    logic [INDEX_BITS-1:0] dst_reg, dst_next;
    logic [POS_W-1:0]      left_reg, left_next;
    logic                  pend_reg, pend_next;

    logic in_fire;

    // execute-stage results
    logic                  first;
    logic                  cut0;
    logic [INDEX_BITS-1:0] rd_gap, wr_gap;
    logic [POS_W-1:0]      rp1, wp1, held0, held1;
    logic [POS_W-1:0]      x_rp, x_wp, x_lock, x_held;
    logic                  x_cut, x_open;
    status_t               x_status;
    logic                  x_write, x_read, x_erase;
    logic [POS_W-1:0]      x_moves;
    logic [INDEX_BITS-1:0] x_base;

    // store ports
    logic                  ram_wr_en, ram_rd_en;
    logic [INDEX_BITS-1:0] ram_wr_addr, ram_rd_addr;
    logic [DATA_W-1:0]     ram_wr_data, ram_rd_data;

    llbr_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign in_fire = in_valid && in_ready;

    // Execute: position adjust, held count, lock update and clamp.
    always_comb
    begin
        first  = !open_reg;
        cut0   = first ? 1'b0 : cut_reg;
        rd_gap = wp_reg[INDEX_BITS-1:0] - start_reg;
        wr_gap = start_reg - rp_reg[INDEX_BITS-1:0];
        rp1    = rp_reg;
        wp1    = wp_reg;
        if (wrap_reg && first && use_start_reg && (op_reg == OP_READ))
        begin
            rp1 = wp_reg - {1'b0, rd_gap};
        end
        if (wrap_reg && first && use_start_reg && (op_reg == OP_WRITE))
        begin
            wp1 = rp_reg + {1'b0, wr_gap};
        end
        held0 = wp_reg - rp_reg;
        held1 = wp1 - rp1;

        x_rp     = rp_reg;
        x_wp     = wp_reg;
        x_lock   = lock_reg;
        x_held   = held0;
        x_cut    = cut_reg;
        x_open   = open_reg;
        x_status = ST_OK;
        x_write  = 1'b0;
        x_read   = 1'b0;
        x_erase  = 1'b0;
        x_moves  = POS_W'(offset_reg) - ONE;
        x_base   = wp_reg[INDEX_BITS-1:0] - offset_reg[INDEX_BITS-1:0];

        unique case (op_reg)
            OP_WRITE, OP_READ:
            begin
                x_cut = cut0;
                if (!wrap_reg)
                begin
                    x_status = ST_UNSUPPORTED;
                end
                else
                begin
                    x_rp   = rp1;
                    x_wp   = wp1;
                    x_held = held1;
                    if (op_reg == OP_WRITE)
                    begin
                        if (held1 >= STORE_SIZE)
                        begin
                            x_status = ST_FULL;
                        end
                        else
                        begin
                            x_write = 1'b1;
                            x_wp    = wp1 + ONE;
                            x_held  = held1 + ONE;
                            if (data_reg == NEWLINE)
                            begin
                                x_lock = held1 + ONE;
                            end
                        end
                    end
                    else
                    begin
                        if (cut0)
                        begin
                            x_status = ST_EMPTY;
                        end
                        else if (held1 == '0)
                        begin
                            x_status = ST_EMPTY;
                            x_cut    = 1'b1;
                        end
                        else
                        begin
                            x_read = 1'b1;
                            x_rp   = rp1 + ONE;
                            x_held = held1 - ONE;
                            if (lock_reg != '0)
                            begin
                                x_lock = lock_reg - ONE;
                                if (lock_reg == ONE)
                                begin
                                    x_cut = 1'b1;
                                end
                            end
                        end
                    end
                end
                x_open = !last_reg;
                if (last_reg)
                begin
                    x_cut = 1'b0;
                end
            end
            OP_ERASE:
            begin
                if (!wrap_reg)
                begin
                    x_status = ST_UNSUPPORTED;
                end
                else if ((held0 == '0) || (offset_reg == '0) ||
                         (COUNT_W'(offset_reg) > COUNT_W'(held0)))
                begin
                    x_status = ST_EMPTY;
                end
                else
                begin
                    x_erase = 1'b1;
                    x_wp    = wp_reg - ONE;
                    x_held  = held0 - ONE;
                end
            end
            OP_FLUSH:
            begin
                if (!wrap_reg)
                begin
                    x_status = ST_UNSUPPORTED;
                end
                else
                begin
                    x_rp   = wp_reg;
                    x_lock = '0;
                    x_held = '0;
                end
            end
        endcase

        if (x_lock > x_held)
        begin
            x_lock = x_held;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (x_erase && (x_moves != '0))
                begin
                    state_next = S_ERASE;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end
            S_ERASE:
            begin
                if (left_reg == '0)
                begin
                    state_next = S_RESP;
                end
            end
            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = in_fire ? S_EXEC : S_IDLE;
                end
            end
        endcase
    end

    // Outputs: handshake and store ports
    always_comb
    begin
        in_ready    = (state_reg == S_IDLE) || ((state_reg == S_RESP) && res_ready);
        res_valid   = (state_reg == S_RESP);
        ram_wr_en   = 1'b0;
        ram_wr_addr = dst_reg;
        ram_wr_data = ram_rd_data;
        ram_rd_en   = 1'b0;
        ram_rd_addr = src_reg;
        unique case (state_reg)
            S_EXEC:
            begin
                ram_wr_en   = x_write;
                ram_wr_addr = wp1[INDEX_BITS-1:0];
                ram_wr_data = data_reg;
                ram_rd_en   = x_read;
                ram_rd_addr = rp1[INDEX_BITS-1:0];
            end
            S_ERASE:
            begin
                ram_wr_en = pend_reg;
                ram_rd_en = (left_reg != '0);
            end
            S_IDLE, S_RESP:
            begin
                ram_wr_en = 1'b0;
                ram_rd_en = 1'b0;
            end
        endcase
    end

    assign res.data_out   = data_sel_reg ? ram_rd_data : '0;
    assign res.status     = status_reg;
    assign res.line_ready = (lock_reg != '0);
    assign res.held_count = COUNT_W'(wp_reg - rp_reg);

    // Datapath next values
    always_comb
    begin
        rp_next       = rp_reg;
        wp_next       = wp_reg;
        lock_next     = lock_reg;
        open_next     = open_reg;
        cut_next      = cut_reg;
        status_next   = status_reg;
        data_sel_next = data_sel_reg;
        src_next      = src_reg;
        dst_next      = dst_reg;
        left_next     = left_reg;
        pend_next     = 1'b0;
        if (state_reg == S_EXEC)
        begin
            rp_next       = x_rp;
            wp_next       = x_wp;
            lock_next     = x_lock;
            open_next     = x_open;
            cut_next      = x_cut;
            status_next   = x_status;
            data_sel_next = x_read;
            src_next      = x_base + INDEX_BITS'(1);
            left_next     = x_erase ? x_moves : '0;
        end
        else if (state_reg == S_ERASE)
        begin
            // shift one byte down per cycle; each write, registered behind its read, lands one place lower
            if (left_reg != '0)
            begin
                src_next  = src_reg + INDEX_BITS'(1);
                dst_next  = src_reg - INDEX_BITS'(1);
                left_next = left_reg - ONE;
                pend_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            rp_reg       <= '0;
            wp_reg       <= '0;
            lock_reg     <= '0;
            open_reg     <= 1'b0;
            cut_reg      <= 1'b0;
            wrap_reg     <= 1'b1;
            status_reg   <= ST_OK;
            data_sel_reg <= 1'b0;
            left_reg     <= '0;
            pend_reg     <= 1'b0;
            op_reg       <= OP_WRITE;
        end
        else
        begin
            state_reg    <= state_next;
            rp_reg       <= rp_next;
            wp_reg       <= wp_next;
            lock_reg     <= lock_next;
            open_reg     <= open_next;
            cut_reg      <= cut_next;
            status_reg   <= status_next;
            data_sel_reg <= data_sel_next;
            left_reg     <= left_next;
            pend_reg     <= pend_next;
            if (cfg_wr_en)
            begin
                wrap_reg <= cfg_wr_data;
            end
            if (in_fire)
            begin
                op_reg <= op_t'(op);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        src_reg <= src_next;
        dst_reg <= dst_next;
        if (in_fire)
        begin
            data_reg      <= data_in;
            last_reg      <= last_of_call;
            use_start_reg <= use_start;
            start_reg     <= start_index[INDEX_BITS-1:0];
            offset_reg    <= erase_offset;
        end
    end

endmodule

// ----- hw/rtl/llbr_checker.sv -----
// llbr_checker: port-level assertions for line_locked_byte_ring_unit.
// Depends on llbr_pkg; bound to the top level at the end of this file.
module llbr_checker
    import llbr_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic               out_valid,
    input logic               out_ready,
    input logic [DATA_W-1:0]  data_out,
    input logic [1:0]         status,
    input logic               line_ready,
    input logic [COUNT_W-1:0] held_count
);

    localparam logic [COUNT_W-1:0] STORE_SIZE = COUNT_W'(1 << INDEX_BITS);

    // held count never exceeds the store
    a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (held_count <= STORE_SIZE))
        else $error("held_count above store size");

    // a line lock always has bytes behind it
    a_lock_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && line_ready) |-> (held_count != '0))
        else $error("line_ready with nothing held");

    // only a good read carries data
    a_data_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status != ST_OK)) |-> (data_out == '0))
        else $error("data_out nonzero on a failed transaction");

    // the block is not ready again in the cycle after it accepts a transaction
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("in_ready high right after an accepted transaction");

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(data_out) && $stable(status) &&
             $stable(line_ready) && $stable(held_count)))
        else $error("output changed while stalled");

endmodule

bind line_locked_byte_ring_unit llbr_checker #(
    .INDEX_BITS (INDEX_BITS)
) u_llbr_checker (.*);

// ----- tb/line_locked_byte_ring_unit_test.sv -----
`timescale 1ns / 1ps
// line_locked_byte_ring_unit_test: self-checking bench for the line-locked byte ring.
// Walks a directed table, then random call streams, against a local ring predictor.
// Depends on llbr_pkg and line_locked_byte_ring_unit.
module line_locked_byte_ring_unit_test;
    import llbr_pkg::*;

    localparam int ADDR_BITS    = 16;
    localparam int RING_DEPTH   = 1 << ADDR_BITS;
    localparam int MAX_GAP      = 18;
    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 24;

    // One byte operation as presented on the input channel.
    typedef struct packed {
        op_t                op;
        logic [DATA_W-1:0]  data;
        logic               last;
        logic               use_start;
        logic [FIELD_W-1:0] start;
        logic [FIELD_W-1:0] offset;
    } byte_op_t;

    // Directed row: mode to run in, the transaction, and an optional hand-typed result.
    typedef struct {
        bit       wrap;
        byte_op_t cmd;
        bit       typed;
        result_t  want;
    } table_row_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic               cfg_wr_data = 1'b1;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [1:0]         op = 2'b00;
    logic [DATA_W-1:0]  data_in = '0;
    logic               last_of_call = 1'b0;
    logic               use_start = 1'b0;
    logic [FIELD_W-1:0] start_index = '0;
    logic [FIELD_W-1:0] erase_offset = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [DATA_W-1:0]  data_out;
    logic [1:0]         status;
    logic               line_ready;
    logic [COUNT_W-1:0] held_count;

    // Predictor copy of the ring: bytes, which entries were ever written, pointers, lock.
    logic [DATA_W-1:0]  ring_bytes [RING_DEPTH];
    bit                 ring_written [RING_DEPTH];
    logic [COUNT_W-1:0] rd_pos = '0;
    logic [COUNT_W-1:0] wr_pos = '0;
    logic [COUNT_W-1:0] lock_left = '0;
    bit                 call_open = 1'b0;
    bit                 read_cut = 1'b0;
    bit                 wrap_on = 1'b1;

    result_t     pending_results [$];
    table_row_t  directed_rows [$];
    int unsigned mismatch_count = 0;
    int unsigned cycle_count = 0;
    int          send_calm = 0;
    int          recv_calm = 0;

    line_locked_byte_ring_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .op           (op),
        .data_in      (data_in),
        .last_of_call (last_of_call),
        .use_start    (use_start),
        .start_index  (start_index),
        .erase_offset (erase_offset),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .data_out     (data_out),
        .status       (status),
        .line_ready   (line_ready),
        .held_count   (held_count)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Bound the run; a hang anywhere ends here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Draw an idle count; now and then open a stretch with no idling at all.
    function automatic int pick_gap(inout int calm_left);
        if (calm_left > 0)
        begin
            calm_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
        begin
            calm_left = $urandom_range(15, 60);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Advance the ring by one transaction and produce the result it must give.
    task automatic advance_ring(input byte_op_t cmd, output result_t res);
        logic [COUNT_W-1:0]   held;
        logic [COUNT_W-1:0]   base;
        logic [ADDR_BITS-1:0] slot;
        bit                   first;
        int                   i;
        res = '0;
        res.status = ST_OK;
        if (cmd.op == OP_WRITE || cmd.op == OP_READ)
        begin
            // Framing is tracked even with wrapping switched off.
            first = !call_open;
            if (first)
                read_cut = 1'b0;
            if (!wrap_on)
                res.status = ST_UNSUPPORTED;
            else
            begin
                if (first && cmd.use_start)
                begin
                    // Explicit start: keep the position within one ring of the other pointer.
                    if (cmd.op == OP_READ)
                        rd_pos = wr_pos - {1'b0, wr_pos[ADDR_BITS-1:0] - cmd.start};
                    else
                        wr_pos = rd_pos + {1'b0, cmd.start - rd_pos[ADDR_BITS-1:0]};
                end
                held = wr_pos - rd_pos;
                if (cmd.op == OP_WRITE)
                begin
                    if (held[ADDR_BITS])
                        res.status = ST_FULL;
                    else
                    begin
                        ring_bytes[wr_pos[ADDR_BITS-1:0]] = cmd.data;
                        ring_written[wr_pos[ADDR_BITS-1:0]] = 1'b1;
                        wr_pos = wr_pos + 1'b1;
                        if (cmd.data == NEWLINE)
                            lock_left = held + 1'b1;
                    end
                end
                else if (read_cut)
                    res.status = ST_EMPTY;
                else if (held == 0)
                begin
                    // An empty read cuts off the rest of the call.
                    res.status = ST_EMPTY;
                    read_cut = 1'b1;
                end
                else
                begin
                    res.data_out = ring_bytes[rd_pos[ADDR_BITS-1:0]];
                    rd_pos = rd_pos + 1'b1;
                    if (lock_left != 0)
                    begin
                        lock_left = lock_left - 1'b1;
                        if (lock_left == 0)
                            read_cut = 1'b1;
                    end
                end
            end
            call_open = !cmd.last;
            if (cmd.last)
                read_cut = 1'b0;
        end
        else if (!wrap_on)
            res.status = ST_UNSUPPORTED;
        else if (cmd.op == OP_ERASE)
        begin
            held = wr_pos - rd_pos;
            if (held == 0 || cmd.offset == 0 || {1'b0, cmd.offset} > held)
                res.status = ST_EMPTY;
            else
            begin
                // Shift the bytes after the erased one down by one place.
                base = wr_pos - {1'b0, cmd.offset};
                for (i = 0; i + 1 < cmd.offset; i++)
                begin
                    slot = base[ADDR_BITS-1:0] + i[ADDR_BITS-1:0];
                    ring_bytes[slot] = ring_bytes[slot + 1'b1];
                    ring_written[slot] = 1'b1;
                end
                wr_pos = wr_pos - 1'b1;
            end
        end
        else
        begin
            rd_pos = wr_pos;
            lock_left = '0;
        end
        held = wr_pos - rd_pos;
        if (lock_left > held)
            lock_left = held;
        res.line_ready = (lock_left != 0);
        res.held_count = held;
    endtask

    // True when the transaction would fetch a ring entry that was never written.
    function automatic bit hits_unwritten(byte_op_t cmd);
        logic [COUNT_W-1:0]   rp;
        logic [COUNT_W-1:0]   held;
        logic [ADDR_BITS-1:0] slot;
        int                   i;
        if (!wrap_on)
            return 1'b0;
        if (cmd.op == OP_READ)
        begin
            rp = rd_pos;
            if (!call_open && cmd.use_start)
                rp = wr_pos - {1'b0, wr_pos[ADDR_BITS-1:0] - cmd.start};
            held = wr_pos - rp;
            if ((call_open && read_cut) || held == 0)
                return 1'b0;
            return !ring_written[rp[ADDR_BITS-1:0]];
        end
        if (cmd.op == OP_ERASE)
        begin
            held = wr_pos - rd_pos;
            if (held == 0 || cmd.offset == 0 || {1'b0, cmd.offset} > held)
                return 1'b0;
            slot = wr_pos[ADDR_BITS-1:0] - cmd.offset;
            for (i = 1; i < cmd.offset; i++)
                if (!ring_written[slot + i[ADDR_BITS-1:0]])
                    return 1'b1;
        end
        return 1'b0;
    endfunction

    // Pick an explicit start near the live data most of the time, anywhere otherwise.
    function automatic logic [FIELD_W-1:0] pick_start(op_t o);
        if ($urandom_range(0, 3) == 0)
            return FIELD_W'($urandom);
        if (o == OP_READ)
            return wr_pos[ADDR_BITS-1:0] - FIELD_W'($urandom_range(0, 24));
        return wr_pos[ADDR_BITS-1:0] + FIELD_W'($urandom_range(0, 6)) - 16'd3;
    endfunction

    // Present one transaction, hold it until taken, then queue what it must return.
    task automatic send_op(input byte_op_t cmd, input bit typed, input result_t want);
        int      gap;
        result_t predicted;
        gap = pick_gap(send_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= cmd.op;
        data_in      <= cmd.data;
        last_of_call <= cmd.last;
        use_start    <= cmd.use_start;
        start_index  <= cmd.start;
        erase_offset <= cmd.offset;
        do
            @(posedge clk);
        while (!(in_valid && in_ready === 1'b1));
        advance_ring(cmd, predicted);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Steer a random transaction away from never-written entries, then send it.
    task automatic send_random(input byte_op_t cmd);
        result_t unused;
        unused = '0;
        if (hits_unwritten(cmd) && cmd.op == OP_READ && cmd.use_start)
            cmd.use_start = 1'b0;
        if (hits_unwritten(cmd))
        begin
            if (cmd.op == OP_ERASE)
                cmd.offset = 16'd1;
            else
                cmd.op = OP_FLUSH;
        end
        send_op(cmd, 1'b0, unused);
    endtask

    // Drain, then write the mode register while the block is idle.
    task automatic set_wrap(input bit enable);
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= enable;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        wrap_on = enable;
    endtask

    task automatic add_row(input bit wrap, input op_t o, input logic [7:0] d, input bit l,
                           input bit us, input logic [15:0] s, input logic [15:0] off,
                           input bit typed, input logic [7:0] dout, input status_t st,
                           input bit lr, input logic [16:0] held);
        table_row_t row;
        row.wrap          = wrap;
        row.cmd.op        = o;
        row.cmd.data      = d;
        row.cmd.last      = l;
        row.cmd.use_start = us;
        row.cmd.start     = s;
        row.cmd.offset    = off;
        row.typed         = typed;
        row.want.data_out   = dout;
        row.want.status     = st;
        row.want.line_ready = lr;
        row.want.held_count = held;
        directed_rows.push_back(row);
    endtask

    // Random stream: mostly well-formed write and read calls, plus erases, flushes,
    // calls left open and fully random transactions.
    task automatic run_calls(input int n_ops);
        int       sent;
        int       kind;
        int       len;
        int       k;
        int       held;
        bit       broken;
        byte_op_t cmd;
        sent = 0;
        while (sent < n_ops)
        begin
            kind = $urandom_range(0, 99);
            broken = ($urandom_range(0, 9) == 0);
            held = int'(wr_pos - rd_pos);
            if (kind < 75)
            begin
                len = (kind < 40) ? $urandom_range(1, 10) : $urandom_range(1, 14);
                for (k = 0; k < len; k++)
                begin
                    cmd = '0;
                    cmd.op = (kind < 40) ? OP_WRITE : OP_READ;
                    cmd.data = DATA_W'($urandom);
                    // Favor a newline at the end of a write call, sprinkle a few inside.
                    if (kind < 40 && ($urandom_range(0, 6) == 0 ||
                                      (k == len - 1 && $urandom_range(0, 4) < 3)))
                        cmd.data = NEWLINE;
                    cmd.last = (k == len - 1) && !broken;
                    if (k == 0 && $urandom_range(0, 6) == 0)
                    begin
                        cmd.use_start = 1'b1;
                        cmd.start = pick_start(cmd.op);
                    end
                    cmd.offset = FIELD_W'($urandom);
                    send_random(cmd);
                    sent++;
                end
            end
            else if (kind < 87)
            begin
                cmd = byte_op_t'({$urandom, $urandom});
                cmd.op = OP_ERASE;
                k = $urandom_range(0, 9);
                if (k < 6 && held > 0)
                    cmd.offset = FIELD_W'($urandom_range(1, (held < 40) ? held : 40));
                else if (k < 9)
                    cmd.offset = FIELD_W'($urandom_range(0, 64));
                send_random(cmd);
                sent++;
            end
            else if (kind < 90)
            begin
                cmd = byte_op_t'({$urandom, $urandom});
                cmd.op = OP_FLUSH;
                send_random(cmd);
                sent++;
            end
            else
            begin
                // Noise: every field random.
                cmd = byte_op_t'({$urandom, $urandom});
                send_random(cmd);
                sent++;
            end
        end
    endtask

    task automatic check_result(input result_t want);
        if (data_out !== want.data_out)
        begin
            $error("data_out: expected %0h, got %0h", want.data_out, data_out);
            mismatch_count++;
        end
        if (status !== want.status)
        begin
            $error("status: expected %0d, got %0d", want.status, status);
            mismatch_count++;
        end
        if (line_ready !== want.line_ready)
        begin
            $error("line_ready: expected %0d, got %0d", want.line_ready, line_ready);
            mismatch_count++;
        end
        if (held_count !== want.held_count)
        begin
            $error("held_count: expected %0d, got %0d", want.held_count, held_count);
            mismatch_count++;
        end
    endtask

    // Result side: stall at random, compare each transaction with the oldest expectation.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            gap = pick_gap(recv_calm);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid === 1'b1 && out_ready));
            if (pending_results.size() == 0)
            begin
                $error("unexpected result: status %0d, held_count %0d", status, held_count);
                mismatch_count++;
            end
            else
                check_result(pending_results.pop_front());
        end
    end

    initial
    begin
        // Directed table, run from reset; wrapping is on out of reset.
        //      wrap op         data     last us start    offset  typed dout  status   lr held
        add_row(1, OP_READ,  8'h00,   1, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_EMPTY, 0, 17'd0);
        add_row(1, OP_ERASE, 8'h00,   0, 0, 16'h0000, 16'h0001, 1, 8'h00, ST_EMPTY, 0, 17'd0);
        add_row(1, OP_FLUSH, 8'h00,   0, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_OK,    0, 17'd0);
        add_row(1, OP_WRITE, 8'h00,   0, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_OK,    0, 17'd1);
        add_row(1, OP_WRITE, 8'hFF,   0, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_OK,    0, 17'd2);
        // Newline locks the three bytes held through it.
        add_row(1, OP_WRITE, NEWLINE, 1, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_OK,    1, 17'd3);
        add_row(1, OP_WRITE, 8'h41,   1, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_OK,    1, 17'd4);
        add_row(1, OP_READ,  8'h00,   0, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_OK,    1, 17'd3);
        add_row(1, OP_READ,  8'h00,   0, 0, 16'h0000, 16'h0000, 1, 8'hFF, ST_OK,    1, 17'd2);
        add_row(1, OP_READ,  8'h00,   0, 0, 16'h0000, 16'h0000, 1, NEWLINE, ST_OK,  0, 17'd1);
        // Lock ran out: the rest of this read call is refused.
        add_row(1, OP_READ,  8'h00,   1, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_EMPTY, 0, 17'd1);
        add_row(1, OP_ERASE, 8'h00,   0, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_EMPTY, 0, 17'd1);
        add_row(1, OP_ERASE, 8'h00,   0, 0, 16'h0000, 16'hFFFF, 1, 8'h00, ST_EMPTY, 0, 17'd1);
        add_row(1, OP_WRITE, 8'h61,   0, 0, 16'h0000, 16'h0000, 0, 8'h00, ST_OK,    0, 17'd0);
        add_row(1, OP_WRITE, 8'h62,   0, 0, 16'h0000, 16'h0000, 0, 8'h00, ST_OK,    0, 17'd0);
        add_row(1, OP_WRITE, 8'h63,   1, 0, 16'h0000, 16'h0000, 0, 8'h00, ST_OK,    0, 17'd0);
        add_row(1, OP_ERASE, 8'h00,   0, 0, 16'h0000, 16'h0003, 0, 8'h00, ST_OK,    0, 17'd0);
        add_row(1, OP_FLUSH, 8'h00,   0, 0, 16'h0000, 16'h0000, 0, 8'h00, ST_OK,    0, 17'd0);
        // Jump the write pointer a whole ring ahead: the store fills with one byte.
        add_row(1, OP_WRITE, NEWLINE, 0, 1, 16'h0005, 16'h0000, 1, 8'h00, ST_OK, 1, 17'd65536);
        add_row(1, OP_WRITE, 8'h33,   1, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_FULL, 1, 17'd65536);
        // Read start at the write address on a full ring reads as empty.
        add_row(1, OP_READ,  8'h00,   1, 1, 16'h0006, 16'h0000, 1, 8'h00, ST_EMPTY, 0, 17'd0);
        add_row(1, OP_READ,  8'h00,   0, 1, 16'h0003, 16'h0000, 0, 8'h00, ST_OK,    0, 17'd0);
        add_row(1, OP_READ,  8'h00,   1, 0, 16'h0000, 16'h0000, 0, 8'h00, ST_OK,    0, 17'd0);
        // Wrapping off: every operation is unsupported, framing still moves.
        add_row(0, OP_WRITE, 8'h7F, 0, 1, 16'hFFFF, 16'h0000, 1, 8'h00, ST_UNSUPPORTED, 0, 17'd1);
        add_row(0, OP_READ,  8'h00, 1, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_UNSUPPORTED, 0, 17'd1);
        add_row(0, OP_ERASE, 8'h00, 0, 0, 16'h0000, 16'h0001, 1, 8'h00, ST_UNSUPPORTED, 0, 17'd1);
        add_row(0, OP_FLUSH, 8'h00, 0, 0, 16'h0000, 16'h0000, 1, 8'h00, ST_UNSUPPORTED, 0, 17'd1);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            if (directed_rows[i].wrap != wrap_on)
                set_wrap(directed_rows[i].wrap);
            send_op(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
        end

        // Random phases: wrapping on, briefly off, on again.
        set_wrap(1'b1);
        run_calls(700);
        set_wrap(1'b0);
        run_calls(60);
        set_wrap(1'b1);
        run_calls(790);

        // Drop valid, drain the expectations, then let the pipeline settle.
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
